// File: sv/vcrh_pkg.sv
// Shared types and constants of the vowel/consonant run-length histogram.
// Holds stream widths, opcode and run-kind codes, and the character set.
// No dependencies.
package vcrh_pkg;

	// Stream widths
	localparam int S_DATA_W  = 16;
	localparam int S_USER_W  = 2;
	localparam int M_DATA_W  = 40;
	localparam int M_USER_W  = 2;
	localparam int CH_W      = 8;
	localparam int BIN_IN_W  = 4;
	localparam int LEN_OUT_W = 4;
	localparam int READ_W    = 32;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_FLUSH = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Kind of the open run
	typedef enum logic [1:0] {
		KIND_NONE  = 2'b00,
		KIND_VOWEL = 2'b01,
		KIND_CONS  = 2'b10
	} kind_t;

	// Character codes
	localparam logic [CH_W-1:0] CH_A     = 8'h61;
	localparam logic [CH_W-1:0] CH_E     = 8'h65;
	localparam logic [CH_W-1:0] CH_I     = 8'h69;
	localparam logic [CH_W-1:0] CH_O     = 8'h6F;
	localparam logic [CH_W-1:0] CH_U     = 8'h75;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

	function automatic logic is_vowel(input logic [CH_W-1:0] c);
		return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) || (c == CH_U);
	endfunction

	function automatic logic is_delim(input logic [CH_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_CR);
	endfunction

endpackage

// File: sv/vcrh_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the histogram bin storage. No dependencies.
module vcrh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, and register read data (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/vowel_consonant_run_histogram.sv
// Top level of the vowel/consonant run-length histogram.
// Depends on vcrh_pkg and vcrh_ram.
//
//   channel   dir  tdata                                  tuser
//   s_axis    in   ch[7:0] read_table[8] read_bin[12:9]   opcode[1:0]
//   m_axis    out  counted_length[3:0] read_value[35:4]   counted[0] counted_table[1]
//
// One item per cycle unless the output stalls; each item's result passes stage 1 and the output register.
// The rate is set by the bin RAM: one read at acceptance, one read-modify-write in stage 1,
// with the last write forwarded to the next item.
// Reset clears the run state and marks every bin as zero through per-entry valid bits.
// A stalled result holds in the output register; stage 1 still takes one more item.
module vowel_consonant_run_histogram #(
	parameter int NUM_BINS   = 12,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [vcrh_pkg::S_DATA_W-1:0] s_axis_tdata,  // ch, read_table, read_bin
	input  logic [vcrh_pkg::S_USER_W-1:0] s_axis_tuser,  // opcode
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [vcrh_pkg::M_DATA_W-1:0] m_axis_tdata,  // counted_length, read_value
	output logic [vcrh_pkg::M_USER_W-1:0] m_axis_tuser   // counted, counted_table
);

	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int LEN_W  = $clog2(NUM_BINS + 1);
	localparam int CMP_W  = (LEN_W > vcrh_pkg::BIN_IN_W) ? LEN_W : vcrh_pkg::BIN_IN_W;
	localparam int ADDR_W = BIN_W + 1;
	localparam int DEPTH  = 2 ** ADDR_W;

	// Input unpacking
	vcrh_pkg::op_t                 op;
	logic [vcrh_pkg::CH_W-1:0]     ch;
	logic                          in_tbl;
	logic [vcrh_pkg::BIN_IN_W-1:0] in_bin;
	logic [CMP_W-1:0]              bin_ext;

	assign op      = vcrh_pkg::op_t'(s_axis_tuser);
	assign ch      = s_axis_tdata[7:0];
	assign in_tbl  = s_axis_tdata[8];
	assign in_bin  = s_axis_tdata[12:9];
	assign bin_ext = CMP_W'(in_bin);

	// Run state
	vcrh_pkg::kind_t run_kind_q;
	logic [LEN_W-1:0] run_length_q;

	// Stage 1 and output registers
	logic              valid_s1;
	logic              cnt_s1;
	logic              tbl_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              rd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              ent_valid_s1;

	logic                             out_valid_q;
	logic                             counted_q;
	logic                             counted_table_q;
	logic [vcrh_pkg::LEN_OUT_W-1:0]   counted_length_q;
	logic [vcrh_pkg::READ_W-1:0]      read_value_q;

	// Bin storage, write forwarding and entry valid bits
	logic [DEPTH-1:0]      entry_valid_q;
	logic                  fwd_valid_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] inc;
	logic                  wr_en;

	// Handshake
	logic accept;
	logic adv_s1;

	assign adv_s1        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Next run state and close decision
	vcrh_pkg::kind_t  kind_nx;
	vcrh_pkg::kind_t  char_kind;
	logic [LEN_W-1:0] len_nx;
	logic             run_open;
	logic             close;
	logic             counted;
	logic             is_read;
	logic             cnt_tbl;
	logic [ADDR_W-1:0] rd_addr;

	assign run_open  = (run_kind_q == vcrh_pkg::KIND_VOWEL) || (run_kind_q == vcrh_pkg::KIND_CONS);
	assign char_kind = vcrh_pkg::is_vowel(ch) ? vcrh_pkg::KIND_VOWEL : vcrh_pkg::KIND_CONS;
	assign cnt_tbl   = (run_kind_q == vcrh_pkg::KIND_CONS);

	always_comb begin
		kind_nx = run_kind_q;
		len_nx  = run_length_q;
		close   = 1'b0;
		is_read = 1'b0;
		case (op)
			vcrh_pkg::OP_CHAR: begin
				if (vcrh_pkg::is_delim(ch)) begin
					close   = run_open;
					kind_nx = vcrh_pkg::KIND_NONE;
					len_nx  = '0;
				end else if (run_kind_q == char_kind) begin
					if (run_length_q < LEN_W'(NUM_BINS)) begin
						len_nx = run_length_q + 1'b1;
					end
				end else begin
					close   = run_open;
					kind_nx = char_kind;
					len_nx  = LEN_W'(1);
				end
			end
			vcrh_pkg::OP_FLUSH: begin
				close   = run_open;
				kind_nx = vcrh_pkg::KIND_NONE;
				len_nx  = '0;
			end
			vcrh_pkg::OP_READ: begin
				is_read = (bin_ext < CMP_W'(NUM_BINS));
			end
			default: begin
			end
		endcase
	end

	assign counted = close && (run_length_q < LEN_W'(NUM_BINS));
	assign rd_addr = (op == vcrh_pkg::OP_READ) ? {in_tbl, bin_ext[BIN_W-1:0]}
	                                           : {cnt_tbl, run_length_q[BIN_W-1:0]};

	// Advance run state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_kind_q   <= vcrh_pkg::KIND_NONE;
			run_length_q <= '0;
		end else if (accept) begin
			run_kind_q   <= kind_nx;
			run_length_q <= len_nx;
		end
	end

	// Stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1       <= counted;
			tbl_s1       <= cnt_tbl;
			len_s1       <= run_length_q;
			rd_s1        <= is_read;
			addr_s1      <= rd_addr;
			ent_valid_s1 <= entry_valid_q[rd_addr];
		end
	end

	vcrh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_bins (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(inc),
		.re   (accept && (counted || is_read)),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Current bin value: forwarded write, else RAM, else zero for an unwritten bin
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			cur = fwd_data_q;
		end else if (ent_valid_s1) begin
			cur = ram_rdata;
		end else begin
			cur = '0;
		end
	end

	// Saturating increment
	assign inc   = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + 1'b1;
	assign wr_en = valid_s1 && adv_s1 && cnt_s1;

	// Track written bins and the last write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			fwd_valid_q   <= 1'b0;
		end else if (wr_en) begin
			entry_valid_q[addr_s1] <= 1'b1;
			fwd_valid_q            <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= inc;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			counted_q        <= cnt_s1;
			counted_table_q  <= cnt_s1 && tbl_s1;
			counted_length_q <= cnt_s1 ? vcrh_pkg::LEN_OUT_W'(len_s1) : '0;
			read_value_q     <= rd_s1 ? vcrh_pkg::READ_W'(cur) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, read_value_q, counted_length_q};
	assign m_axis_tuser  = {counted_table_q, counted_q};

endmodule

// File: sv/vcrh_chk.sv
// Port-level checker for the vowel/consonant run-length histogram, with its bind.
// Depends on vcrh_pkg and the top level vowel_consonant_run_histogram.
module vcrh_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [vcrh_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic [vcrh_pkg::M_USER_W-1:0] m_axis_tuser
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Input backpressure only while a result waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// A count and a read never share one result
	a_count_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[35:4] == '0)
		else $error("counted result carries read data");

	// Uncounted results carry no table or length
	a_uncounted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata[3:0] == '0)
		else $error("uncounted result carries count fields");

	// A new result follows an accepted transaction through stage 1 and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching input");

endmodule

bind vowel_consonant_run_histogram vcrh_chk u_vcrh_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// File: dv/vowel_consonant_run_histogram_tb.sv
// Self-checking testbench for the vowel/consonant run-length histogram.
// Drives directed and random text streams through the slave stream and checks each result.
// Depends on vcrh_pkg and the vowel_consonant_run_histogram RTL.
module vowel_consonant_run_histogram_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_BINS        = 12;
	localparam int COUNT_W          = 32;
	localparam int STALL_LIMIT      = 5000;
	localparam int RANDOM_PER_PHASE = 600;
	localparam int DRAIN_CYCLES     = 8;
	localparam logic [vcrh_pkg::CH_W-1:0] CH_LF = 8'h0A;

	typedef struct packed {
		vcrh_pkg::op_t                 op;
		logic [vcrh_pkg::CH_W-1:0]     ch;
		logic                          tbl;
		logic [3:0]                    bin;
	} hist_item_t;

	typedef struct packed {
		logic               counted;
		logic               counted_table;
		logic [3:0]         counted_length;
		logic [COUNT_W-1:0] read_value;
	} hist_result_t;

	typedef struct {
		hist_item_t   item;
		int           reps;
		bit           typed;
		hist_result_t want;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [vcrh_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
	logic [vcrh_pkg::S_USER_W-1:0]   s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [vcrh_pkg::M_DATA_W-1:0]   m_axis_tdata;
	logic [vcrh_pkg::M_USER_W-1:0]   m_axis_tuser;

	// Predictor state
	vcrh_pkg::kind_t    run_kind = vcrh_pkg::KIND_NONE;
	int                 run_len = 0;
	logic [COUNT_W-1:0] vowel_hist [HIST_BINS];
	logic [COUNT_W-1:0] cons_hist [HIST_BINS];

	hist_result_t expected_results [$];
	stim_row_t    directed_rows [$];

	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int errors = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int runs_counted = 0;
	int runs_dropped = 0;
	int reads_issued = 0;

	vowel_consonant_run_histogram #(
		.NUM_BINS   (HIST_BINS),
		.COUNT_BITS (COUNT_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // ch[7:0], read_table[8], read_bin[12:9]
		.s_axis_tuser  (s_axis_tuser),   // opcode[1:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // counted_length[3:0], read_value[35:4]
		.m_axis_tuser  (m_axis_tuser)    // counted[0], counted_table[1]
	);

	always #2 clk = ~clk;

	function automatic bit is_vowel_byte(input logic [vcrh_pkg::CH_W-1:0] c);
		return c == vcrh_pkg::CH_A || c == vcrh_pkg::CH_E || c == vcrh_pkg::CH_I ||
			c == vcrh_pkg::CH_O || c == vcrh_pkg::CH_U;
	endfunction

	function automatic bit ends_run_byte(input logic [vcrh_pkg::CH_W-1:0] c);
		return c == vcrh_pkg::CH_SPACE || c == vcrh_pkg::CH_CR;
	endfunction

	function automatic hist_item_t mk_item(input vcrh_pkg::op_t op,
			input logic [vcrh_pkg::CH_W-1:0] ch, input logic tbl, input logic [3:0] bin);
		hist_item_t it;
		it.op = op;
		it.ch = ch;
		it.tbl = tbl;
		it.bin = bin;
		return it;
	endfunction

	// Close the open run and bump its bin unless it is too long
	task automatic close_open_run(inout hist_result_t res);
		vcrh_pkg::kind_t k;
		int              len;
		k = run_kind;
		len = run_len;
		run_kind = vcrh_pkg::KIND_NONE;
		run_len = 0;
		if (k == vcrh_pkg::KIND_VOWEL || k == vcrh_pkg::KIND_CONS) begin
			if (len >= HIST_BINS) begin
				runs_dropped++;
			end else begin
				if (k == vcrh_pkg::KIND_VOWEL) begin
					if (vowel_hist[len] != '1) vowel_hist[len]++;
				end else begin
					if (cons_hist[len] != '1) cons_hist[len]++;
				end
				res.counted = 1'b1;
				res.counted_table = (k == vcrh_pkg::KIND_CONS);
				res.counted_length = 4'(len);
				runs_counted++;
			end
		end
	endtask

	// Extend a run of this kind, or close the other kind and start fresh
	task automatic grow_run(input vcrh_pkg::kind_t k, inout hist_result_t res);
		if (run_kind == k) begin
			if (run_len < HIST_BINS) run_len++;
		end else begin
			close_open_run(res);
			run_kind = k;
			run_len = 1;
		end
	endtask

	task automatic predict_histogram(input hist_item_t it, output hist_result_t res);
		res = '0;
		case (it.op)
			vcrh_pkg::OP_CHAR: begin
				if (is_vowel_byte(it.ch)) grow_run(vcrh_pkg::KIND_VOWEL, res);
				else if (ends_run_byte(it.ch)) close_open_run(res);
				else grow_run(vcrh_pkg::KIND_CONS, res);
			end
			vcrh_pkg::OP_FLUSH: begin
				close_open_run(res);
			end
			vcrh_pkg::OP_READ: begin
				reads_issued++;
				if (it.bin < HIST_BINS)
					res.read_value = it.tbl ? cons_hist[it.bin] : vowel_hist[it.bin];
			end
			default: ;
		endcase
	endtask

	// Offer one transaction, wait for acceptance, then queue its expected result
	task automatic drive_item(input hist_item_t it, input bit typed, input hist_result_t want);
		hist_result_t res;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, it.bin, it.tbl, it.ch};
		s_axis_tuser <= it.op;
		do @(posedge clk); while (!s_axis_tready);
		predict_histogram(it, res);
		expected_results.push_back(typed ? want : res);
		items_accepted++;
	endtask

	task automatic add_row(input vcrh_pkg::op_t op, input logic [vcrh_pkg::CH_W-1:0] ch,
			input logic tbl, input logic [3:0] bin, input int reps, input bit typed,
			input hist_result_t want);
		stim_row_t row;
		row.item = mk_item(op, ch, tbl, bin);
		row.reps = reps;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	function automatic logic [vcrh_pkg::CH_W-1:0] pick_vowel();
		case ($urandom_range(0, 4))
			0: return vcrh_pkg::CH_A;
			1: return vcrh_pkg::CH_E;
			2: return vcrh_pkg::CH_I;
			3: return vcrh_pkg::CH_O;
			default: return vcrh_pkg::CH_U;
		endcase
	endfunction

	// Mostly lowercase letters, with newlines and arbitrary bytes mixed in
	function automatic logic [vcrh_pkg::CH_W-1:0] pick_consonant();
		logic [vcrh_pkg::CH_W-1:0] c;
		do begin
			case ($urandom_range(0, 9))
				0: c = CH_LF;
				1, 2: c = 8'($urandom_range(0, 255));
				default: c = vcrh_pkg::CH_A + 8'($urandom_range(0, 25));
			endcase
		end while (is_vowel_byte(c) || ends_run_byte(c));
		return c;
	endfunction

	// One random chunk: a run of one kind, a delimiter, a flush, a read or noise
	task automatic send_random_chunk(output int sent);
		int         pick;
		int         len;
		bit         vowel_run;
		logic [3:0] bin;
		sent = 0;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			vowel_run = 1'($urandom_range(0, 1));
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
			repeat (len) begin
				drive_item(mk_item(vcrh_pkg::OP_CHAR,
					vowel_run ? pick_vowel() : pick_consonant(),
					1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))), 1'b0, '0);
				sent++;
			end
		end else if (pick < 75) begin
			drive_item(mk_item(vcrh_pkg::OP_CHAR,
				$urandom_range(0, 1) ? vcrh_pkg::CH_SPACE : vcrh_pkg::CH_CR,
				1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))), 1'b0, '0);
			sent = 1;
		end else if (pick < 83) begin
			drive_item(mk_item(vcrh_pkg::OP_FLUSH, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))), 1'b0, '0);
			sent = 1;
		end else if (pick < 95) begin
			bin = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
			                                  : 4'($urandom_range(0, 11));
			drive_item(mk_item(vcrh_pkg::OP_READ, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), bin), 1'b0, '0);
			sent = 1;
		end else if ($urandom_range(0, 1) == 0) begin
			// Ignored opcode: does not count toward the phase's item total
			drive_item(mk_item(vcrh_pkg::OP_NOP, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))), 1'b0, '0);
		end else begin
			drive_item(mk_item(vcrh_pkg::OP_CHAR, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))), 1'b0, '0);
			sent = 1;
		end
	endtask

	task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
			input logic [COUNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		hist_result_t want;
		hist_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.counted = m_axis_tuser[0];
			got.counted_table = m_axis_tuser[1];
			got.counted_length = m_axis_tdata[3:0];
			got.read_value = m_axis_tdata[35:4];
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("counted", COUNT_W'(want.counted), COUNT_W'(got.counted));
				check_field("counted_table", COUNT_W'(want.counted_table),
					COUNT_W'(got.counted_table));
				check_field("counted_length", COUNT_W'(want.counted_length),
					COUNT_W'(got.counted_length));
				check_field("read_value", want.read_value, got.read_value);
				results_checked++;
			end
		end
	end

	// Stop on a long stretch with no transaction on either side
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall = 0;
			else stall++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int           sent;
		int           phase_items;
		hist_result_t zero_res;
		hist_result_t max_vowel_run;
		zero_res = '0;
		max_vowel_run = {1'b1, 1'b0, 4'd11, 32'd0};
		foreach (vowel_hist[i]) begin
			vowel_hist[i] = '0;
			cons_hist[i] = '0;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: cleared tables, ignored opcode, out-of-range read, empty closes,
		// kind switches, newline as consonant, over-long vowel run, longest counted run
		add_row(vcrh_pkg::OP_READ,  8'h00, 1'b0, 4'd0,  1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_READ,  8'hFF, 1'b1, 4'd11, 1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_NOP,   8'hFF, 1'b1, 4'd15, 1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_READ,  8'h00, 1'b1, 4'd15, 1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_SPACE, 1'b0, 4'd0, 1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_FLUSH, 8'h00, 1'b0, 4'd0,  1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_A, 1'b0, 4'd0, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_A + 8'd1, 1'b0, 4'd0, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  CH_LF, 1'b0, 4'd0,  1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  8'h00, 1'b1, 4'd15, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_CR, 1'b0, 4'd0, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_E, 1'b0, 4'd0, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_I, 1'b0, 4'd0, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_U, 1'b0, 4'd0, 12, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  8'hFF, 1'b0, 4'd0,  1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_FLUSH, 8'hFF, 1'b1, 4'd15, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_O, 1'b0, 4'd0, 11, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_READ,  8'h00, 1'b0, 4'd1,  1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_CHAR,  vcrh_pkg::CH_SPACE, 1'b0, 4'd0, 1, 1'b1, max_vowel_run);
		add_row(vcrh_pkg::OP_READ,  8'h00, 1'b0, 4'd11, 1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_READ,  8'h00, 1'b1, 4'd1,  1, 1'b0, zero_res);
		add_row(vcrh_pkg::OP_NOP,   vcrh_pkg::CH_A, 1'b0, 4'd0, 1, 1'b1, zero_res);
		add_row(vcrh_pkg::OP_READ,  8'h00, 1'b1, 4'd3,  1, 1'b0, zero_res);

		src_idle_pct = 21;
		dst_idle_pct = 72;
		foreach (directed_rows[i])
			repeat (directed_rows[i].reps)
				drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		// Random text in three backpressure phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 21;
					dst_idle_pct = 72;
				end
				1: begin
					src_idle_pct = 72;
					dst_idle_pct = 21;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			phase_items = 0;
			while (phase_items < RANDOM_PER_PHASE) begin
				send_random_chunk(sent);
				phase_items += sent;
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions in, checked %0d results, %0d bin reads.",
			items_accepted, results_checked, reads_issued);
		$display("Runs counted: %0d, over-long runs dropped: %0d.", runs_counted, runs_dropped);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
